>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("RTL assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons))

`endif

>>> rtl/pcdb_pkg.sv
package pcdb_pkg;

   localparam int ACC_WIDTH        = 32;
   localparam int BYTES_PER_SAMPLE = 8;
   localparam int PDM_W            = 64;
   localparam int PCM_W            = 16;

   typedef logic [ACC_WIDTH-1:0] acc_type;
   typedef logic [3:0]           ones_type;

   localparam int D1_W = 7;
   localparam int D2_W = 9;
   localparam int D3_W = 10;

   typedef struct packed {
      logic [D3_W-1:0] d3;
      logic [D2_W-1:0] d2;
      logic [D1_W-1:0] d1;
   } incr_type;

   localparam int BYTE_ORDER [BYTES_PER_SAMPLE] = '{3, 2, 1, 0, 7, 6, 5, 4};
   localparam int W2 [BYTES_PER_SAMPLE] = '{8, 7, 6, 5, 4, 3, 2, 1};
   localparam int W3 [BYTES_PER_SAMPLE] = '{36, 28, 21, 15, 10, 6, 3, 1};

   localparam acc_type I2_FROM_I1 = acc_type'(BYTES_PER_SAMPLE);
   localparam acc_type I3_FROM_I2 = acc_type'(BYTES_PER_SAMPLE);
   localparam acc_type I3_FROM_I1 = acc_type'(BYTES_PER_SAMPLE * (BYTES_PER_SAMPLE + 1) / 2);

   localparam int      BLOCK_SHIFT = 6;
   localparam acc_type BLOCK_GAIN  = acc_type'(63);
   localparam acc_type BLOCK_BIAS  = acc_type'((1 << BLOCK_SHIFT) - 1);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef struct packed {
      logic     valid;
      incr_type incr;
   } q_word_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
   } q_stat_type;

   function automatic ones_type ones_count(input logic [7:0] b);
      ones_type n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + ones_type'(b[i]);
      end
      return n;
   endfunction

endpackage

>>> rtl/pcdb_if.sv
interface pcdb_req_if;
   import pcdb_pkg::*;
   logic             valid;
   logic             ready;
   logic [PDM_W-1:0] pdm_word;
   modport source (output valid, output pdm_word, input ready);
   modport sink (input valid, input pdm_word, output ready);
endinterface

interface pcdb_rsp_if;
   import pcdb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [PCM_W-1:0] pcm_sample;
   modport source (output valid, output pcm_sample, input ready);
   modport sink (input valid, input pcm_sample, output ready);
endinterface

>>> rtl/pcdb_front.sv
module pcdb_front import pcdb_pkg::*; (
   pcdb_req_if.sink   req_if,
   input  logic       push_ready,
   output q_word_type push_word
);

   ones_type cnt [BYTES_PER_SAMPLE];

   // Each beat is reduced to the increments that eight integrator steps add.
   always_comb begin
      for (int k = 0; k < BYTES_PER_SAMPLE; k++) begin
         cnt[k] = ones_count(req_if.pdm_word[BYTE_ORDER[k]*8 +: 8]);
      end
   end

   always_comb begin
      push_word.valid   = req_if.valid;
      push_word.incr.d1 = '0;
      push_word.incr.d2 = '0;
      push_word.incr.d3 = '0;
      for (int k = 0; k < BYTES_PER_SAMPLE; k++) begin
         push_word.incr.d1 = push_word.incr.d1 + D1_W'(cnt[k]);
         push_word.incr.d2 = push_word.incr.d2 + D2_W'(int'(cnt[k]) * W2[k]);
         push_word.incr.d3 = push_word.incr.d3 + D3_W'(int'(cnt[k]) * W3[k]);
      end
   end

   assign req_if.ready = push_ready;

endmodule

>>> rtl/pcdb_queue.sv
module pcdb_queue import pcdb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_word_type push_word,
   output logic       push_ready,
   input  logic       pop,
   output q_word_type head,
   output q_stat_type stat
);

   incr_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;

   assign push_ready = count_ff != QCNT_W'(QDEPTH);
   assign push       = push_word.valid && push_ready;
   assign head.valid = count_ff != '0;
   assign head.incr  = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word.incr;
      end
   end

endmodule

>>> rtl/pcdb_back.sv
module pcdb_back import pcdb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_word_type head,
   output logic       pop,
   pcdb_rsp_if.source rsp_if
);

   acc_type i1_ff, i1_in, i2_ff, i2_in, i3_ff, i3_in;
   acc_type c1d_ff [2];
   acc_type c2d_ff [2];
   acc_type c3d_ff [2];
   acc_type x_ff, x_in, xprev_ff, y_ff, y_in;
   acc_type c1, c2, s, v, vb;
   logic    s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign pop     = advance && head.valid;

   always_comb begin
      i1_in = i1_ff + acc_type'(head.incr.d1);
      i2_in = i2_ff + i1_ff * I2_FROM_I1 + acc_type'(head.incr.d2);
      i3_in = i3_ff + i2_ff * I3_FROM_I2 + i1_ff * I3_FROM_I1 + acc_type'(head.incr.d3);
      c1    = i3_ff - c1d_ff[1];
      c2    = c1 - c2d_ff[1];
      x_in  = c2 - c3d_ff[1];
      s     = y_ff + x_ff - xprev_ff;
      v     = s * BLOCK_GAIN;
      // A negative value is biased before the shift so the quotient truncates toward zero.
      vb    = v + (v[ACC_WIDTH-1] ? BLOCK_BIAS : '0);
      y_in  = acc_type'($signed(vb) >>> BLOCK_SHIFT);
      s1_valid_in  = advance ? pop : s1_valid_ff;
      s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = advance ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i1_ff        <= '0;
         i2_ff        <= '0;
         i3_ff        <= '0;
         c1d_ff       <= '{default: '0};
         c2d_ff       <= '{default: '0};
         c3d_ff       <= '{default: '0};
         x_ff         <= '0;
         xprev_ff     <= '0;
         y_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            i1_ff <= i1_in;
            i2_ff <= i2_in;
            i3_ff <= i3_in;
         end
         if (advance && s1_valid_ff) begin
            c1d_ff[1] <= c1d_ff[0];
            c1d_ff[0] <= i3_ff;
            c2d_ff[1] <= c2d_ff[0];
            c2d_ff[0] <= c1;
            c3d_ff[1] <= c3d_ff[0];
            c3d_ff[0] <= c2;
            x_ff      <= x_in;
         end
         if (advance && s2_valid_ff) begin
            xprev_ff <= x_ff;
            y_ff     <= y_in;
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pcm_sample = y_ff[PCM_W-1:0];

endmodule

>>> rtl/pdm_cic_decimator_dc_block.sv
// An accepted beat goes through the queue, integrator, comb and y registers.
// Throughput: one 64-bit word per cycle unless the output stalls, as the DC
// blocker loop closes on y_ff and the eight-byte integrator step is closed-form.
// Reset (synchronous, active high) clears all filter state, the queue and valids.
`include "assert_macros.svh"

module pdm_cic_decimator_dc_block import pcdb_pkg::*; (
   input logic        clock,
   input logic        reset,
   pcdb_req_if.sink   req_if,
   pcdb_rsp_if.source rsp_if
);

   q_word_type push_word;
   q_word_type head;
   q_stat_type stat;
   logic       push_ready;
   logic       pop;

   pcdb_front u_front (
      .req_if     (req_if),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   pcdb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_word  (push_word),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   pcdb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

   `ASSERT_CLK(a_queue_bound, clock, reset, stat.count <= QCNT_W'(QDEPTH))
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, stat.count != '0)
   `ASSERT_CLK(a_accept_lands, clock, reset, (req_if.valid && req_if.ready) |=> (stat.count != '0))

endmodule
